@@ hdl/tsrc_pkg.sv @@
// Shared types, codes and reset values for the timestamp rate calibrator.
package tsrc_pkg;

  // Fixed field widths
  localparam int FIELD_W    = 64;
  localparam int REQ_W      = 2;
  localparam int WIN_W      = 10;
  localparam int SAMP_W     = 16;
  localparam int CNT_W      = 32;
  localparam int ATT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Defaults for the top-level parameters
  localparam int STAMP_W_DEF  = 64;
  localparam int ATTEMPTS_DEF = 3;

  // Spike check factor and the first attempt that may fall back
  localparam logic [3:0]       SPIKE_FACTOR     = 4'd10;
  localparam logic [ATT_W-1:0] FALLBACK_ATTEMPT = 2'd2;

  // Configuration reset values
  localparam logic [WIN_W-1:0]  WINDOW_MS_RST         = 10'd10;
  localparam logic [SAMP_W-1:0] MIN_SAMPLES_RST       = 16'd1000;
  localparam logic [WIN_W-1:0]  RETRY_WINDOW_MS_RST   = 10'd100;
  localparam logic [SAMP_W-1:0] RETRY_MIN_SAMPLES_RST = 16'd10000;

  typedef enum logic [REQ_W-1:0] {
    REQ_START      = 2'd0,
    REQ_SAMPLE     = 2'd1,
    REQ_WINDOW_END = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_MS         = 2'd0,
    CFG_MIN_SAMPLES       = 2'd1,
    CFG_RETRY_WINDOW_MS   = 2'd2,
    CFG_RETRY_MIN_SAMPLES = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CHECK = 2'd1,
    ST_DIV   = 2'd2,
    ST_DONE  = 2'd3
  } state_t;

endpackage

@@ hdl/tsrc_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
module tsrc_div #(
  parameter int STAMP_WIDTH = tsrc_pkg::STAMP_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [STAMP_WIDTH-1:0]        dividend,
  input  logic [tsrc_pkg::WIN_W-1:0]    divisor,
  output logic                          done,
  output logic [STAMP_WIDTH-1:0]        quotient
);
  import tsrc_pkg::*;

  localparam int STEP_W = $clog2(STAMP_WIDTH + 1);

  logic [STEP_W-1:0]      step_r;
  logic [WIN_W-1:0]       rem_r;
  logic [STAMP_WIDTH-1:0] quo_r;
  logic [WIN_W-1:0]       dsr_r;
  logic [WIN_W:0]         shifted;
  logic [WIN_W+1:0]       trial;
  logic                   borrow;

  // Shift in the next dividend bit and try a subtract
  assign shifted = {rem_r, quo_r[STAMP_WIDTH-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr_r};
  assign borrow  = trial[WIN_W+1];

  // Last iteration completes on this edge
  assign done     = (step_r == STEP_W'(1));
  assign quotient = quo_r;

  // Count steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (start) begin
      step_r <= STEP_W'(STAMP_WIDTH);
    end else if (step_r != '0) begin
      step_r <= step_r - 1'b1;
    end
  end

  // Advance remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (step_r != '0) begin
      rem_r <= borrow ? shifted[WIN_W-1:0] : trial[WIN_W-1:0];
      quo_r <= {quo_r[STAMP_WIDTH-2:0], ~borrow};
    end
  end

endmodule

@@ hdl/timestamp_rate_calibrator_unit.sv @@
// Top level of the timestamp rate calibrator.
// Start and sample items may follow back to back.
// A window end passes to its result through a check state, the bit-serial divider and
// a done state that loads the output register once it is free.
// Input stalls while a window end is in progress; the output register holds a result
// until it is taken. Synchronous active-low reset restores configuration defaults
// and leaves the block unarmed at attempt zero.
module timestamp_rate_calibrator_unit #(
  parameter int STAMP_WIDTH = tsrc_pkg::STAMP_W_DEF,
  parameter int ATTEMPTS    = tsrc_pkg::ATTEMPTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_wr_en,
  input  logic [tsrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsrc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [tsrc_pkg::REQ_W-1:0]         in_req_type,
  input  logic [tsrc_pkg::FIELD_W-1:0]       in_stamp,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tsrc_pkg::FIELD_W-1:0]       out_ticks_per_ms,
  output logic                               out_attempt_ok,
  output logic [tsrc_pkg::FIELD_W-1:0]       out_best_ticks_per_ms,
  output logic [tsrc_pkg::ATT_W-1:0]         out_attempt_index,
  output logic                               out_all_done
);
  import tsrc_pkg::*;

  localparam int PROD_W = STAMP_WIDTH + 4;
  localparam logic [ATT_W-1:0] LAST_ATTEMPT = ATT_W'(ATTEMPTS - 1);

  // configuration registers
  logic [WIN_W-1:0]  window_ms_r;
  logic [SAMP_W-1:0] min_samples_r;
  logic [WIN_W-1:0]  retry_window_ms_r;
  logic [SAMP_W-1:0] retry_min_samples_r;

  // attempt state
  logic [STAMP_WIDTH-1:0] first_stamp_r;
  logic [STAMP_WIDTH-1:0] last_stamp_r;
  logic [STAMP_WIDTH-1:0] min_gap_r;
  logic [STAMP_WIDTH-1:0] max_gap_r;
  logic [STAMP_WIDTH-1:0] gap_r;
  logic                   gap_vld_r;
  logic [CNT_W-1:0]       count_r;
  logic [ATT_W-1:0]       attempt_r;
  logic [FIELD_W-1:0]     best_r;
  logic                   armed_r;

  // window-end working registers
  logic [WIN_W-1:0]  win_r;
  logic [SAMP_W-1:0] floor_r;
  logic              ok_r;

  // result register
  logic                 out_valid_r;
  logic [FIELD_W-1:0]   out_ticks_r;
  logic                 out_ok_r;
  logic [FIELD_W-1:0]   out_best_r;
  logic [ATT_W-1:0]     out_index_r;
  logic                 out_done_r;

  state_t state_r, state_nxt;

  logic                   in_xfer;
  logic                   out_xfer;
  logic                   is_start;
  logic                   is_sample;
  logic                   is_end;
  logic [STAMP_WIDTH-1:0] stamp;
  logic                   fallback;
  logic [WIN_W-1:0]       win_sel;
  logic [PROD_W-1:0]      spike_limit;
  logic                   spike;
  logic                   ok_now;
  logic [STAMP_WIDTH-1:0] elapsed;
  logic                   div_start;
  logic                   div_done;
  logic [STAMP_WIDTH-1:0] div_q;
  logic                   load_out;
  logic [FIELD_W-1:0]     rate;
  logic [FIELD_W-1:0]     best_nxt;
  logic                   last_att;

  // Decode the accepted transfer
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign stamp     = in_stamp[STAMP_WIDTH-1:0];
  assign is_start  = in_xfer && (in_req_type == REQ_START);
  assign is_sample = in_xfer && (in_req_type == REQ_SAMPLE) && armed_r;
  assign is_end    = in_xfer && (in_req_type == REQ_WINDOW_END) && armed_r;

  // Pick window and sample floor for this attempt
  assign fallback = (attempt_r >= FALLBACK_ATTEMPT) && (best_r == '1);
  assign win_sel  = fallback ? retry_window_ms_r : window_ms_r;

  // Check sample floor and gap spikes
  assign spike_limit = PROD_W'(min_gap_r) * PROD_W'(SPIKE_FACTOR);
  assign spike       = PROD_W'(max_gap_r) > spike_limit;
  assign ok_now      = !((count_r < CNT_W'(floor_r)) || spike);
  assign elapsed     = last_stamp_r - first_stamp_r;

  // Final rate and running minimum
  assign rate     = ok_r ? FIELD_W'(div_q) : '1;
  assign best_nxt = (rate < best_r) ? rate : best_r;
  assign last_att = (attempt_r == LAST_ATTEMPT);

  tsrc_div #(
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (elapsed),
    .divisor  (win_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Hold the state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and sequencing strobes
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (is_end) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ms_r         <= WINDOW_MS_RST;
      min_samples_r       <= MIN_SAMPLES_RST;
      retry_window_ms_r   <= RETRY_WINDOW_MS_RST;
      retry_min_samples_r <= RETRY_MIN_SAMPLES_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WINDOW_MS:         window_ms_r         <= cfg_data[WIN_W-1:0];
        CFG_MIN_SAMPLES:       min_samples_r       <= cfg_data[SAMP_W-1:0];
        CFG_RETRY_WINDOW_MS:   retry_window_ms_r   <= cfg_data[WIN_W-1:0];
        CFG_RETRY_MIN_SAMPLES: retry_min_samples_r <= cfg_data[SAMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Track attempt control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r   <= 1'b0;
      attempt_r <= '0;
      best_r    <= '1;
      count_r   <= '0;
      gap_vld_r <= 1'b0;
      min_gap_r <= '1;
      max_gap_r <= '0;
    end else begin
      gap_vld_r <= is_sample;
      // fold the registered gap into the extremes
      if (gap_vld_r) begin
        if (gap_r < min_gap_r) min_gap_r <= gap_r;
        if (gap_r > max_gap_r) max_gap_r <= gap_r;
      end
      if (is_sample && (count_r != '1)) begin
        count_r <= count_r + 1'b1;
      end
      // a start discards any running attempt, including a gap in flight
      if (is_start) begin
        if (attempt_r == '0) best_r <= '1;
        count_r   <= '0;
        min_gap_r <= '1;
        max_gap_r <= '0;
        gap_vld_r <= 1'b0;
        armed_r   <= 1'b1;
      end
      if (load_out) begin
        best_r    <= best_nxt;
        attempt_r <= last_att ? '0 : attempt_r + 1'b1;
        armed_r   <= 1'b0;
      end
    end
  end

  // Capture stamps and gaps
  always_ff @(posedge clk) begin
    if (is_start) begin
      first_stamp_r <= stamp;
      last_stamp_r  <= stamp;
    end else if (is_sample) begin
      last_stamp_r <= stamp;
      gap_r        <= stamp - last_stamp_r;
    end
  end

  // Latch window parameters at window end, verdict in the check cycle
  always_ff @(posedge clk) begin
    if (is_end) begin
      win_r   <= (win_sel == '0) ? WIN_W'(1) : win_sel;
      floor_r <= fallback ? retry_min_samples_r : min_samples_r;
    end
    if (state_r == ST_CHECK) begin
      ok_r <= ok_now;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ticks_r <= rate;
      out_ok_r    <= ok_r;
      out_best_r  <= best_nxt;
      out_index_r <= attempt_r;
      out_done_r  <= last_att;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_ticks_per_ms      = out_ticks_r;
  assign out_attempt_ok        = out_ok_r;
  assign out_best_ticks_per_ms = out_best_r;
  assign out_attempt_index     = out_index_r;
  assign out_all_done          = out_done_r;

  // A result appears only after the final sequencing cycle
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the final cycle");

  // Divider finishes only while the sequencer waits on it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide phase");

  // The finishing flag marks the last attempt only
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> (out_index_r == LAST_ATTEMPT))
    else $error("calibration finished on the wrong attempt");

  // The attempt counter never passes the last attempt
  a_attempt_range: assert property (@(posedge clk) disable iff (!rst_n)
    attempt_r <= LAST_ATTEMPT)
    else $error("attempt counter out of range");

  // The running best never exceeds this attempt's rate
  a_best_le_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_best_r <= out_ticks_r))
    else $error("best rate above attempt rate");

endmodule
